[rtl/lsuf_pkg.sv]
// ----------------------------------------------------------------------------
// lsuf_pkg: shared types and constants for the lattice site union-find unit
// ----------------------------------------------------------------------------
package lsuf_pkg;

    localparam int unsigned SIDE_DEF = 256;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;

    localparam logic CMD_OCCUPY = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHK_RD,
        S_CHK_WT,
        S_NB_RD,
        S_NB_WT,
        S_WALK_WT,
        S_CMP_RD,
        S_CMP_WT,
        S_MERGE,
        S_DONE
    } state_t;

endpackage

[rtl/lsuf_ram.sv]
// ----------------------------------------------------------------------------
// lsuf_ram: single port synchronous ram, registered read
// ----------------------------------------------------------------------------
module lsuf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/lattice_site_union_find_unit.sv]
// ----------------------------------------------------------------------------
// lattice_site_union_find_unit: site percolation with weighted union-find
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tuser=cmd, tdata=site
// m_axis   out  tuser=status, tdata=root_site,cluster_size,merge_count
//
// one item at a time; the single-port link memory sets the rate
// occupy: the site is checked, then each of four neighbours is read; an
// occupied neighbour adds a root walk (one link read per hop) and a
// compression pass that rewrites links, then a merge; ignored items write nothing
// after reset and on each clear a sweep over all SIDE*SIDE cells empties the
// memory, during which no item is accepted
// a finished result waits in the output register; tready stays low until taken
// ----------------------------------------------------------------------------
module lattice_site_union_find_unit #(
    parameter int unsigned SIDE = lsuf_pkg::SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // site
    input  logic        s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // root_site[15:0], cluster_size[32:16], merge_count[35:33]
    output logic [1:0]  m_axis_tuser   // status
);

    localparam int unsigned CELLS = SIDE * SIDE;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned AW1   = AW + 1;
    localparam int unsigned LW    = AW + 1;       // link: parent or size
    localparam int unsigned EW    = LW + 2;       // occupied, root, link
    localparam int unsigned SW    = $clog2(SIDE);
    localparam int unsigned RSH   = 16 + SW;
    // row = (site * RECIP) >> RSH, exact for every 16-bit site
    localparam logic [17:0] RECIP =
        18'(((64'd1 << RSH) + 64'(SIDE) - 64'd1) / 64'(SIDE));

    lsuf_pkg::state_t state_reg, state_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [EW-1:0] wdata, rdata;

    lsuf_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    wire          rd_occ  = rdata[EW-1];
    wire          rd_root = rdata[EW-2];
    wire [LW-1:0] rd_link = rdata[LW-1:0];

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] site_reg, site_next;
    logic [15:0]   row_reg, row_next;
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] r1_reg, r1_next;
    logic [LW-1:0] s1_reg, s1_next;
    logic [AW-1:0] top_reg, top_next;
    logic [LW-1:0] s2_reg, s2_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] nb_reg, nb_next;
    logic [1:0]    dir_reg, dir_next;
    logic [2:0]    mrg_reg, mrg_next;
    logic          ovld_reg, ovld_next;
    logic [1:0]    ost_reg, ost_next;
    logic [15:0]   oroot_reg, oroot_next;
    logic [16:0]   osize_reg, osize_next;
    logic [2:0]    omrg_reg, omrg_next;

    logic [AW-1:0] nb_addr;
    logic [33:0]   row_prod;
    logic [AW:0]   dn_sum;
    logic          in_range;

    assign row_prod = 34'(16'(site_reg)) * 34'(RECIP);
    assign dn_sum   = {1'b0, site_reg} + AW1'(SIDE);
    assign in_range = ({16'd0, s_axis_tdata} < 32'(CELLS));

    always_comb
    begin
        case (dir_reg)
            2'd0:    nb_addr = (col_reg == AW'(SIDE - 1)) ? site_reg - AW'(SIDE - 1)
                                                          : site_reg + AW'(1);
            2'd1:    nb_addr = (col_reg == '0) ? site_reg + AW'(SIDE - 1)
                                               : site_reg - AW'(1);
            2'd2:    nb_addr = (dn_sum >= AW1'(CELLS)) ? AW'(dn_sum - AW1'(CELLS))
                                                       : AW'(dn_sum);
            default: nb_addr = (site_reg >= AW'(SIDE)) ? site_reg - AW'(SIDE)
                                   : AW'({1'b0, site_reg} + AW1'(CELLS - SIDE));
        endcase
    end

    assign s_axis_tready = (state_reg == lsuf_pkg::S_IDLE) && !ovld_reg;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tdata  = {4'd0, omrg_reg, osize_reg, oroot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsuf_pkg::S_CLEAR;
            clr_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        site_reg  <= site_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        r1_reg    <= r1_next;
        s1_reg    <= s1_next;
        top_reg   <= top_next;
        s2_reg    <= s2_next;
        cur_reg   <= cur_next;
        nb_reg    <= nb_next;
        dir_reg   <= dir_next;
        mrg_reg   <= mrg_next;
        ost_reg   <= ost_next;
        oroot_reg <= oroot_next;
        osize_reg <= osize_next;
        omrg_reg  <= omrg_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsuf_pkg::S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tuser == lsuf_pkg::CMD_CLEAR)
                        state_next = lsuf_pkg::S_CLEAR;
                    else if (!in_range)
                        state_next = lsuf_pkg::S_IDLE;
                    else
                        state_next = lsuf_pkg::S_CHK_RD;
                end
            lsuf_pkg::S_CLEAR:
                if (clr_reg == AW'(CELLS - 1))
                    state_next = lsuf_pkg::S_IDLE;
            lsuf_pkg::S_CHK_RD: state_next = lsuf_pkg::S_CHK_WT;
            lsuf_pkg::S_CHK_WT:
                state_next = rd_occ ? lsuf_pkg::S_IDLE : lsuf_pkg::S_NB_RD;
            lsuf_pkg::S_NB_RD:  state_next = lsuf_pkg::S_NB_WT;
            lsuf_pkg::S_NB_WT:
                if (!rd_occ)
                    state_next = (dir_reg == 2'd3) ? lsuf_pkg::S_DONE : lsuf_pkg::S_NB_RD;
                else if (rd_root)
                    state_next = lsuf_pkg::S_CMP_RD;
                else
                    state_next = lsuf_pkg::S_WALK_WT;
            lsuf_pkg::S_WALK_WT:
                if (rd_root)
                    state_next = lsuf_pkg::S_CMP_RD;
            lsuf_pkg::S_CMP_RD: state_next = lsuf_pkg::S_CMP_WT;
            lsuf_pkg::S_CMP_WT:
                // compression pass: rewrite links until the root is reached
                if (cur_reg == top_reg || rd_root)
                    state_next = lsuf_pkg::S_MERGE;
                else
                    state_next = lsuf_pkg::S_CMP_RD;
            lsuf_pkg::S_MERGE:
                state_next = (dir_reg == 2'd3) ? lsuf_pkg::S_DONE : lsuf_pkg::S_NB_RD;
            lsuf_pkg::S_DONE:   state_next = lsuf_pkg::S_IDLE;
            default:            state_next = lsuf_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        clr_next   = clr_reg;
        ovld_next  = ovld_reg && !m_axis_tready;
        site_next  = site_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        r1_next    = r1_reg;
        s1_next    = s1_reg;
        top_next   = top_reg;
        s2_next    = s2_reg;
        cur_next   = cur_reg;
        nb_next    = nb_reg;
        dir_next   = dir_reg;
        mrg_next   = mrg_reg;
        ost_next   = ost_reg;
        oroot_next = oroot_reg;
        osize_next = osize_reg;
        omrg_next  = omrg_reg;
        we         = 1'b0;
        addr       = site_reg;
        wdata      = '0;
        case (state_reg)
            lsuf_pkg::S_IDLE:
            begin
                addr = AW'(s_axis_tdata);
                if (s_axis_tvalid && s_axis_tready)
                begin
                    site_next = AW'(s_axis_tdata);
                    if (s_axis_tuser == lsuf_pkg::CMD_CLEAR)
                    begin
                        clr_next   = '0;
                        ovld_next  = 1'b1;
                        ost_next   = lsuf_pkg::ST_CLEARED;
                        oroot_next = '0;
                        osize_next = '0;
                        omrg_next  = '0;
                    end
                    else if (!in_range)
                    begin
                        ovld_next  = 1'b1;
                        ost_next   = lsuf_pkg::ST_IGNORED;
                        oroot_next = s_axis_tdata;
                        osize_next = '0;
                        omrg_next  = '0;
                    end
                end
            end
            lsuf_pkg::S_CLEAR:
            begin
                we       = 1'b1;
                addr     = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            lsuf_pkg::S_CHK_RD:
            begin
                addr     = site_reg;
                row_next = 16'(row_prod >> RSH);
            end
            lsuf_pkg::S_CHK_WT:
            begin
                col_next = AW'(32'(site_reg) - 32'(row_reg) * SIDE);
                if (rd_occ)
                begin
                    ovld_next  = 1'b1;
                    ost_next   = lsuf_pkg::ST_IGNORED;
                    oroot_next = 16'(site_reg);
                    osize_next = '0;
                    omrg_next  = '0;
                end
                else
                begin
                    we       = 1'b1;
                    addr     = site_reg;
                    wdata    = {1'b1, 1'b1, LW'(1)};
                    r1_next  = site_reg;
                    s1_next  = LW'(1);
                    dir_next = 2'd0;
                    mrg_next = '0;
                end
            end
            lsuf_pkg::S_NB_RD:
            begin
                addr    = nb_addr;
                nb_next = nb_addr;
            end
            lsuf_pkg::S_NB_WT:
            begin
                top_next = nb_reg;
                cur_next = nb_reg;
                s2_next  = rd_link;
                if (!rd_occ)
                    dir_next = dir_reg + 2'd1;
                else if (!rd_root)
                begin
                    addr     = AW'(rd_link);
                    top_next = AW'(rd_link);
                end
            end
            lsuf_pkg::S_WALK_WT:
            begin
                s2_next = rd_link;
                if (!rd_root)
                begin
                    addr     = AW'(rd_link);
                    top_next = AW'(rd_link);
                end
            end
            lsuf_pkg::S_CMP_RD: addr = cur_reg;
            lsuf_pkg::S_CMP_WT:
                if (!(cur_reg == top_reg || rd_root))
                begin
                    we       = 1'b1;
                    addr     = cur_reg;
                    wdata    = {1'b1, 1'b0, LW'(top_reg)};
                    cur_next = AW'(rd_link);
                end
            lsuf_pkg::S_MERGE:
            begin
                dir_next = dir_reg + 2'd1;
                if (top_reg != r1_reg)
                begin
                    mrg_next = mrg_reg + 3'd1;
                    we       = 1'b1;
                    if (s1_reg < s2_reg)
                    begin
                        // current root joins the neighbour root; size updated at the end
                        addr    = r1_reg;
                        wdata   = {1'b1, 1'b0, LW'(top_reg)};
                        r1_next = top_reg;
                        s1_next = s1_reg + s2_reg;
                    end
                    else
                    begin
                        addr    = top_reg;
                        wdata   = {1'b1, 1'b0, LW'(r1_reg)};
                        s1_next = s1_reg + s2_reg;
                    end
                end
            end
            lsuf_pkg::S_DONE:
            begin
                we         = 1'b1;
                addr       = r1_reg;
                wdata      = {1'b1, 1'b1, s1_reg};
                ovld_next  = 1'b1;
                ost_next   = lsuf_pkg::ST_OK;
                oroot_next = 16'(r1_reg);
                osize_next = 17'(s1_reg);
                omrg_next  = mrg_reg;
            end
            default: ;
        endcase
        if (state_reg == lsuf_pkg::S_DONE)
            dir_next = dir_reg;
    end

endmodule

[rtl/lsuf_checker.sv]
// ----------------------------------------------------------------------------
// lsuf_checker: port-level checks for the union-find unit
// ----------------------------------------------------------------------------
module lsuf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // no new item while a result waits
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("item accepted while result pending");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= lsuf_pkg::ST_CLEARED)
        else $error("bad status code");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == lsuf_pkg::ST_CLEARED) |-> m_axis_tdata == 40'd0)
        else $error("clear result not zero");

    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == lsuf_pkg::ST_OK) |-> m_axis_tdata[32:16] != 17'd0)
        else $error("occupy gave empty cluster");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind lattice_site_union_find_unit lsuf_checker u_lsuf_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
